FILE: sv/ttb_pkg.sv
// Shared types and constants of the triangle tangent basis block.
`timescale 1ns / 1ps
package ttb_pkg;

    // Width of one output vector component, signed Q1.x.
    localparam int OUT_BITS = 16;
    // Operand width of the shared signed multiplier.
    localparam int MUL_W = 31;
    // Width of the square-root and dividend working words.
    localparam int WORD_W = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DET,
        ST_VEC,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DINIT,
        ST_DIV,
        ST_EMIT
    } bstate_t;

endpackage

FILE: sv/ttb_queue.sv
// Short first-in first-out queue of whole triangles between front and back.
`timescale 1ns / 1ps
module ttb_queue #(
    parameter int WIDTH = 240,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/ttb_front.sv
// Front end: accepts corners, holds the first two and forms whole triangles.
`timescale 1ns / 1ps
module ttb_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [5*COORD_BITS-1:0]   corner,
    output logic                      push,
    input  logic                      push_ready,
    output logic [15*COORD_BITS-1:0]  tri_data
);

    localparam int CW = 5 * COORD_BITS;

    logic [1:0]    count_reg;
    logic [CW-1:0] corner_a_reg;
    logic [CW-1:0] corner_b_reg;
    logic          third;
    logic          accept;

    // A corner count of three cannot arise; it is handled as a third corner.
    assign third    = count_reg[1];
    assign in_ready = !third || push_ready;
    assign accept   = in_valid && in_ready;
    assign push     = accept && third;
    assign tri_data = {corner, corner_b_reg, corner_a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= third ? 2'd0 : count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (count_reg == 2'd0))
        begin
            corner_a_reg <= corner;
        end
        if (accept && (count_reg == 2'd1))
        begin
            corner_b_reg <= corner;
        end
    end

endmodule

FILE: sv/ttb_back.sv
// Back end: sequenced triangle arithmetic, normalisation and the result register.
`timescale 1ns / 1ps
module ttb_back
    import ttb_pkg::*;
#(
    parameter int COORD_BITS     = 16,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      tri_valid,
    input  logic [15*COORD_BITS-1:0]  tri_data,
    output logic                      tri_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [6*OUT_BITS-1:0]     out_data,
    output logic                      out_degen
);

    localparam int CB  = COORD_BITS;
    localparam int DS  = (CB > 30) ? CB - 30 : 0;
    localparam int PW  = 2 * MUL_W;
    localparam int RW  = PW + 1;
    localparam int QW  = UNIT_FRAC_BITS + 2;
    localparam int LW  = 32;

    bstate_t state_reg;
    bstate_t state_next;

    logic signed [MUL_W-1:0] e1_reg [3];
    logic signed [MUL_W-1:0] e2_reg [3];
    logic signed [MUL_W-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [RW-1:0]    res_reg [7];
    logic signed [PW-1:0]    p_reg;
    logic                    p_valid_reg;
    logic                    p_sq_reg;
    logic                    p_sub_reg;
    logic [2:0]              p_idx_reg;
    logic [WORD_W-1:0]       m_reg [3];
    logic [2:0]              sgn_reg;
    logic [WORD_W-1:0]       sum_reg;
    logic [WORD_W-1:0]       x_reg, r_reg, bit_reg;
    logic [LW-1:0]           len_reg;
    logic [LW:0]             rem_reg;
    logic [WORD_W-1:0]       num_reg;
    logic [QW-1:0]           q_reg;
    logic [5:0]              cnt_reg;
    logic [1:0]              k_reg;
    logic                    vec_reg;
    logic                    neg_reg;
    logic                    deg_reg;
    logic [OUT_BITS-1:0]     unit_reg [6];
    logic                    out_valid_reg;
    logic [6*OUT_BITS-1:0]   out_data_reg;
    logic                    out_degen_reg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic                    issue;
    logic [2:0]              pair;
    logic [1:0]              lane;
    logic signed [RW-1:0]    vsel [3];
    logic [WORD_W-1:0]       mag [3];
    logic                    mag_zero;
    logic                    too_wide;
    logic [WORD_W-1:0]       trial_root;
    logic                    root_ge;
    logic [WORD_W-1:0]       r_next;
    logic [WORD_W-1:0]       x_next;
    logic [WORD_W-1:0]       dividend;
    logic [LW:0]             trial;
    logic [LW:0]             divisor;
    logic                    div_ge;
    logic [QW-1:0]           q_next;
    logic [LW-1:0]           q_wide;
    logic [LW-1:0]           q_signed;
    logic                    emit_ok;

    function automatic logic signed [MUL_W-1:0] delta(input logic [CB-1:0] a,
                                                      input logic [CB-1:0] b);
        logic signed [CB:0] d;
        logic signed [CB:0] sh;
        d  = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
        sh = d >>> DS;
        return MUL_W'(sh);
    endfunction

    function automatic logic [CB-1:0] fld(input logic [15*CB-1:0] t, input int idx);
        return t[idx*CB +: CB];
    endfunction

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_degen = out_degen_reg;
    assign emit_ok   = !out_valid_reg || out_ready;
    assign tri_pop   = (state_reg == ST_IDLE) && tri_valid;

    // Operand selection for the shared multiplier. In the multiply phase products come in pairs:
    // the first of a pair sets an accumulator and the second subtracts from it; squares are summed.
    always_comb
    begin
        pair  = cnt_reg[3:1];
        lane  = 2'd0;
        mul_a = '0;
        mul_b = '0;
        issue = 1'b0;
        case (state_reg)
            ST_MUL:
            begin
                issue = (cnt_reg < 6'd14);
                if (pair == 3'd0)
                begin
                    mul_a = cnt_reg[0] ? du2_reg : du1_reg;
                    mul_b = cnt_reg[0] ? dv1_reg : dv2_reg;
                end
                else if (pair < 3'd4)
                begin
                    lane  = 2'(pair - 3'd1);
                    mul_a = cnt_reg[0] ? dv1_reg : dv2_reg;
                    mul_b = cnt_reg[0] ? e2_reg[lane] : e1_reg[lane];
                end
                else
                begin
                    lane  = 2'(pair - 3'd4);
                    mul_a = cnt_reg[0] ? du2_reg : du1_reg;
                    mul_b = cnt_reg[0] ? e1_reg[lane] : e2_reg[lane];
                end
            end
            ST_SQ:
            begin
                issue = (cnt_reg < 6'd3);
                lane  = (cnt_reg < 6'd3) ? cnt_reg[1:0] : 2'd0;
                mul_a = $signed({1'b0, m_reg[lane][MUL_W-2:0]});
                mul_b = $signed({1'b0, m_reg[lane][MUL_W-2:0]});
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [WORD_W-1:0] vx;
            vx      = WORD_W'(vec_reg ? res_reg[4 + i] : res_reg[1 + i]);
            vsel[i] = vec_reg ? res_reg[4 + i] : res_reg[1 + i];
            mag[i]  = vx[WORD_W-1] ? WORD_W'(-vx) : WORD_W'(vx);
        end
        mag_zero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
        too_wide = ((m_reg[0] >> 30) != '0) || ((m_reg[1] >> 30) != '0)
                || ((m_reg[2] >> 30) != '0);
    end

    // One digit of the integer square root per cycle.
    always_comb
    begin
        trial_root = r_reg + bit_reg;
        root_ge    = (x_reg >= trial_root);
        x_next     = root_ge ? x_reg - trial_root : x_reg;
        r_next     = root_ge ? (r_reg >> 1) + bit_reg : (r_reg >> 1);
    end

    // One quotient bit of the rounding divide per cycle.
    always_comb
    begin
        dividend = (m_reg[k_reg] << (UNIT_FRAC_BITS + 1)) + WORD_W'(len_reg);
        divisor  = {len_reg, 1'b0};
        trial    = {rem_reg[LW-1:0], num_reg[WORD_W-1]};
        div_ge   = (trial >= divisor);
        q_next   = {q_reg[QW-2:0], div_ge};
        q_wide   = LW'(q_next);
        q_signed = (sgn_reg[k_reg] ^ neg_reg) ? -q_wide : q_wide;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tri_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == 6'd14)
                begin
                    state_next = ST_DET;
                end
            end
            ST_DET:
            begin
                state_next = (res_reg[0] == '0) ? ST_EMIT : ST_VEC;
            end
            ST_VEC:
            begin
                state_next = mag_zero ? ST_EMIT : ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (!too_wide)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (cnt_reg == 6'd4)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (bit_reg == WORD_W'(1))
                begin
                    state_next = (r_next == '0) ? ST_EMIT : ST_DINIT;
                end
            end
            ST_DINIT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'(QW - 1))
                begin
                    if (k_reg != 2'd2)
                    begin
                        state_next = ST_DINIT;
                    end
                    else
                    begin
                        state_next = vec_reg ? ST_EMIT : ST_VEC;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= issue;
            if ((state_reg == ST_EMIT) && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= mul_a * mul_b;
        p_sq_reg  <= (state_reg == ST_SQ);
        p_sub_reg <= cnt_reg[0];
        p_idx_reg <= cnt_reg[3:1];

        if (p_valid_reg)
        begin
            if (p_sq_reg)
            begin
                sum_reg <= sum_reg + WORD_W'($unsigned(p_reg));
            end
            else if (p_sub_reg)
            begin
                res_reg[p_idx_reg] <= res_reg[p_idx_reg] - RW'(p_reg);
            end
            else
            begin
                res_reg[p_idx_reg] <= RW'(p_reg);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= delta(fld(tri_data, 5 + i), fld(tri_data, i));
                    e2_reg[i] <= delta(fld(tri_data, 10 + i), fld(tri_data, i));
                end
                du1_reg <= delta(fld(tri_data, 8), fld(tri_data, 3));
                dv1_reg <= delta(fld(tri_data, 9), fld(tri_data, 4));
                du2_reg <= delta(fld(tri_data, 13), fld(tri_data, 3));
                dv2_reg <= delta(fld(tri_data, 14), fld(tri_data, 4));
                cnt_reg <= '0;
                deg_reg <= 1'b0;
            end
            ST_MUL:
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_DET:
            begin
                neg_reg <= res_reg[0][RW-1];
                vec_reg <= 1'b0;
                if (res_reg[0] == '0)
                begin
                    deg_reg <= 1'b1;
                end
            end
            ST_VEC:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i]   <= mag[i];
                    sgn_reg[i] <= vsel[i][RW-1];
                end
                if (mag_zero)
                begin
                    deg_reg <= 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (too_wide)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                end
                cnt_reg <= '0;
                sum_reg <= '0;
            end
            ST_SQ:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                x_reg   <= sum_reg;
                r_reg   <= '0;
                bit_reg <= WORD_W'(1) << (WORD_W - 2);
            end
            ST_SQRT:
            begin
                x_reg   <= x_next;
                r_reg   <= r_next;
                bit_reg <= bit_reg >> 2;
                len_reg <= LW'(r_next);
                k_reg   <= 2'd0;
                if ((bit_reg == WORD_W'(1)) && (r_next == '0))
                begin
                    deg_reg <= 1'b1;
                end
            end
            ST_DINIT:
            begin
                rem_reg <= (LW + 1)'(dividend >> QW);
                num_reg <= dividend << (WORD_W - QW);
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? trial - divisor : trial;
                num_reg <= num_reg << 1;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(QW - 1))
                begin
                    unit_reg[(vec_reg ? 3'd3 : 3'd0) + {1'b0, k_reg}] <= q_signed[OUT_BITS-1:0];
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd2)
                    begin
                        vec_reg <= 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_degen_reg <= deg_reg;
                    out_data_reg  <= deg_reg ? '0 : {unit_reg[5], unit_reg[4], unit_reg[3],
                                                     unit_reg[2], unit_reg[1], unit_reg[0]};
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (len_reg != '0))
        else $error("divide started with a zero length");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_degen_reg) |-> (out_data_reg == '0))
        else $error("degenerate result carries non-zero vectors");

    a_sq_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ) |-> !too_wide)
        else $error("magnitudes not reduced below the square range");

    a_prod_src: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> ($past(state_reg) == ST_MUL || $past(state_reg) == ST_SQ))
        else $error("product taken outside a multiply phase");

endmodule

FILE: sv/triangle_tangent_basis.sv
// A result is made for each triangle after its third corner's transfer, sooner when the
// determinant is zero and sooner when a vector vanishes. The time is set by the bit-serial
// square root (32 steps) and the bit-serial divider (UNIT_FRAC_BITS + 2 steps per component)
// run for both vectors, plus the shift steps that bring each vector into range.
// Throughput: corners are taken one per cycle while the two-triangle queue has room;
// the back end takes a new triangle only after it has emitted the last one.
// Reset: rst_n clears the corner count, queue and result valid at once; no clearing pass.
`timescale 1ns / 1ps
module triangle_tangent_basis
    import ttb_pkg::*;
#(
    parameter int COORD_BITS     = 16,
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, zero padding
    input  logic [((5*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
    output logic [6*OUT_BITS-1:0]                  m_tdata,
    // degenerate
    output logic                                   m_tuser
);

    localparam int CORNER_W = 5 * COORD_BITS;
    localparam int TRI_W    = 15 * COORD_BITS;
    localparam int Q_DEPTH  = 2;

    logic             push;
    logic             push_ready;
    logic [TRI_W-1:0] push_data;
    logic             pop;
    logic             pop_valid;
    logic [TRI_W-1:0] pop_data;

    ttb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .corner     (s_tdata[CORNER_W-1:0]),
        .push       (push),
        .push_ready (push_ready),
        .tri_data   (push_data)
    );

    ttb_queue #(
        .WIDTH (TRI_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    ttb_back #(
        .COORD_BITS     (COORD_BITS),
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (pop_valid),
        .tri_data  (pop_data),
        .tri_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_degen (m_tuser)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the triangle tangent basis block.
`timescale 1ns / 1ps
module testbench
    import ttb_pkg::*;
();

    localparam int SDW = 80;
    localparam longint LIMIT_CYCLES = 1500000;
    localparam int RANDOM_CORNERS = 450;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [15:0] tex_v;
        logic [15:0] tex_u;
        logic [15:0] pos_z;
        logic [15:0] pos_y;
        logic [15:0] pos_x;
    } corner_t;

    typedef struct {
        logic [6*OUT_BITS-1:0] vecs;
        logic                  degen;
    } basis_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SDW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [6*OUT_BITS-1:0] m_tdata;
    logic m_tuser;

    triangle_tangent_basis DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    // Predictor state: corners of the triangle being gathered.
    corner_t held_corners[2];
    int      corners_seen = 0;
    basis_t  pending_bases[$];
    int      mismatches = 0;
    longint  cycle_count = 0;

    function automatic longint isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Unit vector in Q1.14; returns 0 when the vector has no length.
    function automatic bit unit_vec(input longint v[3], input bit neg,
                                    output logic [3*OUT_BITS-1:0] res);
        longint unsigned m[3], mx, sum, len, q;
        int s;
        mx = 0;
        sum = 0;
        s = 0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 0;
        while ((mx >> s) >= (64'd1 << 30)) s++;
        for (int i = 0; i < 3; i++) begin
            m[i] >>= s;
            sum += m[i] * m[i];
        end
        len = isqrt(sum);
        if (len == 0) return 0;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 15) + len) / (2 * len);
            if ((v[i] < 0) != neg) q = -q;
            res[i*OUT_BITS +: OUT_BITS] = q[15:0];
        end
        return 1;
    endfunction

    function automatic basis_t triangle_basis(corner_t a, corner_t b, corner_t c);
        longint e1[3], e2[3], t[3], bt[3], du1, dv1, du2, dv2, det;
        logic [3*OUT_BITS-1:0] tu, bu;
        bit ok;
        basis_t r;
        e1[0] = $signed(b.pos_x) - $signed(a.pos_x);
        e1[1] = $signed(b.pos_y) - $signed(a.pos_y);
        e1[2] = $signed(b.pos_z) - $signed(a.pos_z);
        e2[0] = $signed(c.pos_x) - $signed(a.pos_x);
        e2[1] = $signed(c.pos_y) - $signed(a.pos_y);
        e2[2] = $signed(c.pos_z) - $signed(a.pos_z);
        du1 = $signed(b.tex_u) - $signed(a.tex_u);
        dv1 = $signed(b.tex_v) - $signed(a.tex_v);
        du2 = $signed(c.tex_u) - $signed(a.tex_u);
        dv2 = $signed(c.tex_v) - $signed(a.tex_v);
        det = du1 * dv2 - du2 * dv1;
        for (int i = 0; i < 3; i++) begin
            t[i] = dv2 * e1[i] - dv1 * e2[i];
            bt[i] = du1 * e2[i] - du2 * e1[i];
        end
        ok = det != 0;
        if (ok) ok = unit_vec(t, det < 0, tu);
        if (ok) ok = unit_vec(bt, det < 0, bu);
        r.vecs = ok ? {bu, tu} : '0;
        r.degen = !ok;
        return r;
    endfunction

    function automatic void accept_corner(corner_t c);
        if (corners_seen < 2) begin
            held_corners[corners_seen] = c;
            corners_seen++;
        end
        else begin
            pending_bases.insert(pending_bases.size(),
                                 triangle_basis(held_corners[0], held_corners[1], c));
            corners_seen = 0;
        end
    endfunction

    // Sender: bursts of transfers separated by random gaps.
    task automatic send_corner(corner_t c);
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        accept_corner(c);
    endtask

    function automatic corner_t random_corner();
        corner_t c;
        int k;
        c = 80'({$urandom, $urandom, $urandom});
        k = $urandom_range(0, 3);
        // Small coordinates are used a quarter of the time; full range keeps every bit toggling.
        if (k == 0) begin
            c.pos_x = 16'($signed($urandom_range(0, 512)) - 256);
            c.pos_y = 16'($signed($urandom_range(0, 512)) - 256);
            c.pos_z = 16'($signed($urandom_range(0, 512)) - 256);
            c.tex_u = 16'($signed($urandom_range(0, 8192)) - 4096);
            c.tex_v = 16'($signed($urandom_range(0, 8192)) - 4096);
        end
        return c;
    endfunction

    // Receiver: stalls on its own changing pattern, with free-running stretches.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[9]) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
        if (m_tvalid && m_tready) begin
            if (pending_bases.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %b", m_tdata, m_tuser);
            end
            else begin
                basis_t e;
                e = pending_bases.pop_front();
                if (e.vecs !== m_tdata || e.degen !== m_tuser) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h deg %b, got %h deg %b",
                                 e.vecs, e.degen, m_tdata, m_tuser);
                end
            end
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed corners: extremes, degenerate and signed cases. Rows with a known
    // answer carry it; the rest are predicted.
    corner_t directed[21];
    bit      typed_in[7];
    basis_t  typed_res[7];

    initial begin
        corner_t c, base;
        basis_t  e;
        directed = '{
            // all-zero triangle: degenerate
            80'h0, 80'h0, 80'h0,
            // unit axes, u along x and v along y: tangent +x, bitangent +y
            80'h0, {16'h0, 16'h1000, 16'h0, 16'h0, 16'h0100},
            {16'h1000, 16'h0, 16'h0, 16'h0100, 16'h0},
            // identical UVs: det zero
            {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
            {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000},
            {16'h7FFF, 16'h8000, 16'h1234, 16'h0, 16'h7FFF},
            // full-scale extremes
            {16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
            {16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
            {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000},
            // mirrored UVs: negative det
            80'h0, {16'h0, 16'hF000, 16'h0, 16'h0, 16'h0100},
            {16'h1000, 16'h0, 16'h0, 16'h0100, 16'h0},
            // coincident positions with valid UVs: vectors vanish
            80'h0, {16'h0, 16'h1000, 16'h0, 16'h0, 16'h0},
            {16'h1000, 16'h0, 16'h0, 16'h0, 16'h0},
            // all bits set in the first corner
            {80{1'b1}}, 80'h0, {16'h7FFF, 16'h7FFF, 16'h0, 16'h7FFF, 16'h0}
        };
        typed_in = '{1, 1, 1, 0, 0, 1, 0};
        typed_res[0] = '{'0, 1'b1};
        typed_res[1] = '{{16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000}, 1'b0};
        typed_res[2] = '{'0, 1'b1};
        typed_res[3] = '{'0, 1'b1};
        typed_res[4] = '{'0, 1'b1};
        typed_res[5] = '{'0, 1'b1};
        typed_res[6] = '{'0, 1'b1};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 21; i++) begin
            send_corner(directed[i]);
            if (corners_seen == 0 && typed_in[i/3]) begin
                e = pending_bases[pending_bases.size()-1];
                if (e.vecs !== typed_res[i/3].vecs || e.degen !== typed_res[i/3].degen) begin
                    mismatches++;
                    $display("directed triangle %0d: predictor gives %h deg %b",
                             i/3, e.vecs, e.degen);
                end
                pending_bases[pending_bases.size()-1] = typed_res[i/3];
            end
        end

        // Mostly well-formed triangles: nearby corners around a common base.
        for (int i = 0; i < RANDOM_CORNERS; i++) begin
            if (corners_seen == 0 || $urandom_range(0, 4) == 0) base = random_corner();
            c = random_corner();
            if ($urandom_range(0, 9) == 0) c = base;
            else if ($urandom_range(0, 1) == 0) c = 80'(base) ^ 80'($urandom_range(0, 255));
            send_corner(c);
        end
        while (corners_seen != 0) send_corner(random_corner());
        s_tvalid <= 1'b0;

        while (pending_bases.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: sim.f
sv/ttb_pkg.sv
sv/ttb_queue.sv
sv/ttb_front.sv
sv/ttb_back.sv
sv/triangle_tangent_basis.sv
tb/testbench.sv
